/* src/ssr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the substring replacer
// Payload structs, emitter request codes and register indexes.
// ---------------------------------------------------------------------------
package ssr_pkg;

    localparam int BYTE_W            = 8;
    localparam int WORD_W            = 64;
    localparam int DEPTH_W           = 4;
    localparam int LIMIT_W           = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int REPLACE_MAX       = 8;
    localparam int PATTERN_BYTES_DEF = 8;
    localparam int COUNT_BITS_DEF    = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RLEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

    // emitter request codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              run_last;
        logic              string_end;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] data;
        logic              last;
    } emit_req_t;

    // byte sel of a packed 8-byte word, byte 0 in the low bits
    function automatic logic [BYTE_W-1:0] pick_byte(input logic [WORD_W-1:0] word,
                                                    input logic [2:0] sel);
        pick_byte = word[{sel, 3'b000} +: BYTE_W];
    endfunction

endpackage

/* src/ssr_emit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_emit: byte limiter and output stage
// Holds one byte back so the last result of an item can be marked, counts
// bytes against the limit and drives the output register.
// ---------------------------------------------------------------------------
module ssr_emit
    import ssr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  emit_req_t          req,
    output logic               ready,
    input  logic [LIMIT_W-1:0] limit,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    logic                    pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0]       pend_byte_reg, pend_byte_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    out_valid_reg;
    out_item_t               out_data_reg, out_data_next;
    logic                    out_free;
    logic                    below;
    logic                    load;

    assign out_free = !out_valid_reg || !out_stall;
    assign below    = (CMP_W'(count_reg) < CMP_W'(limit)) && (count_reg != '1);
    assign ready    = (req.op == OP_CLOSE) ? out_free : (!pend_valid_reg || out_free);

    // request decode
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        count_next      = count_reg;
        load            = 1'b0;
        out_data_next   = '0;
        unique case (req.op)
            OP_BYTE:
            begin
                if (ready && below)
                begin
                    count_next      = count_reg + COUNT_BITS'(1);
                    pend_valid_next = 1'b1;
                    pend_byte_next  = req.data;
                    if (pend_valid_reg)
                    begin
                        load                   = 1'b1;
                        out_data_next.out_byte = pend_byte_reg;
                        out_data_next.has_byte = 1'b1;
                    end
                end
            end
            OP_CLOSE:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        load                     = 1'b1;
                        out_data_next.out_byte   = pend_byte_reg;
                        out_data_next.has_byte   = 1'b1;
                        out_data_next.run_last   = 1'b1;
                        out_data_next.string_end = req.last;
                    end
                    else if (req.last)
                    begin
                        // bare end marker
                        load                     = 1'b1;
                        out_data_next.run_last   = 1'b1;
                        out_data_next.string_end = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    if (req.last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/ssr_scan.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_scan: match sequencer with fallback table
// One byte comparator serves both the fallback table build and the per-byte
// match walk; the sequencer issues one output byte per cycle when emit_ready.
// ---------------------------------------------------------------------------
module ssr_scan
    import ssr_pkg::*;
#(
    parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               build_start,
    input  logic [WORD_W-1:0]  pattern,
    input  logic [DEPTH_W-1:0] search_len,
    input  logic [WORD_W-1:0]  replace,
    input  logic [DEPTH_W-1:0] replace_len,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output emit_req_t          emit_req,
    input  logic               emit_ready
);

    localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_BUILD   = 3'd1;
    localparam logic [2:0] S_MATCH   = 3'd2;
    localparam logic [2:0] S_FB_EMIT = 3'd3;
    localparam logic [2:0] S_REPL    = 3'd4;
    localparam logic [2:0] S_TAIL    = 3'd5;
    localparam logic [2:0] S_CLOSE   = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] k_reg, k_next;
    logic [DEPTH_W-1:0] idx_reg, idx_next;
    logic [DEPTH_W-1:0] cnt_reg, cnt_next;
    logic [DEPTH_W-1:0] stop_reg, stop_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               last_reg, last_next;

    logic [DEPTH_W-1:0] fb_reg [PATTERN_BYTES];
    logic               fb_we;
    logic [DEPTH_W-1:0] fb_wdata;

    logic [DEPTH_W-1:0] n_eff;
    logic [DEPTH_W-1:0] r_eff;
    logic               building;
    logic [DEPTH_W-1:0] cmp_sel;
    logic [BYTE_W-1:0]  cmp_a;
    logic [BYTE_W-1:0]  cmp_b;
    logic               eq;
    logic [DEPTH_W-1:0] rd_base;
    logic [DEPTH_W-1:0] rd_dec;
    logic [DEPTH_W-1:0] tbl_rd;
    logic [DEPTH_W-1:0] cnt_inc;
    logic [DEPTH_W-1:0] depth_inc;
    logic [DEPTH_W-1:0] k_step;

    // effective lengths
    assign n_eff = (search_len > DEPTH_W'(PATTERN_BYTES)) ? DEPTH_W'(PATTERN_BYTES)
                                                          : search_len;
    assign r_eff = (replace_len > DEPTH_W'(REPLACE_MAX)) ? DEPTH_W'(REPLACE_MAX)
                                                         : replace_len;

    // shared byte comparator
    assign building = (state_reg == S_BUILD);
    assign cmp_sel  = building ? idx_reg : depth_reg;
    assign cmp_a    = pick_byte(pattern, cmp_sel[2:0]);
    assign cmp_b    = building ? pick_byte(pattern, k_reg[2:0]) : byte_reg;
    assign eq       = (cmp_a == cmp_b);

    // single table read port; border of a one-byte prefix is zero
    assign rd_base = building ? k_reg : depth_reg;
    assign rd_dec  = rd_base - DEPTH_W'(1);
    assign tbl_rd  = (rd_base == DEPTH_W'(1)) ? '0 : fb_reg[rd_dec[IDX_W-1:0]];

    assign cnt_inc   = cnt_reg + DEPTH_W'(1);
    assign depth_inc = depth_reg + DEPTH_W'(1);
    assign k_step    = eq ? (k_reg + DEPTH_W'(1)) : k_reg;

    assign in_stall = (state_reg != S_IDLE) || build_start;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        k_next        = k_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        stop_next     = stop_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        fb_we         = 1'b0;
        fb_wdata      = k_step;
        emit_req.op   = OP_NONE;
        emit_req.data = '0;
        emit_req.last = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !build_start)
                begin
                    byte_next  = in_data.in_byte;
                    last_next  = in_data.in_last;
                    state_next = S_MATCH;
                end
            end
            S_BUILD:
            begin
                if (idx_reg >= n_eff)
                begin
                    state_next = S_IDLE;
                end
                else if (k_reg != '0 && !eq)
                begin
                    k_next = tbl_rd;
                end
                else
                begin
                    fb_we    = 1'b1;
                    k_next   = k_step;
                    idx_next = idx_reg + DEPTH_W'(1);
                end
            end
            S_MATCH:
            begin
                if (n_eff == '0)
                begin
                    // pass through
                    emit_req.op   = OP_BYTE;
                    emit_req.data = byte_reg;
                    if (emit_ready)
                    begin
                        cnt_next   = '0;
                        state_next = S_TAIL;
                    end
                end
                else if (depth_reg != '0 && !eq)
                begin
                    // fall back: release the prefix that no longer fits
                    depth_next = tbl_rd;
                    stop_next  = depth_reg - tbl_rd;
                    cnt_next   = '0;
                    state_next = S_FB_EMIT;
                end
                else if (eq)
                begin
                    cnt_next = '0;
                    if (depth_inc >= n_eff)
                    begin
                        depth_next = '0;
                        state_next = S_REPL;
                    end
                    else
                    begin
                        depth_next = depth_inc;
                        state_next = S_TAIL;
                    end
                end
                else
                begin
                    emit_req.op   = OP_BYTE;
                    emit_req.data = byte_reg;
                    if (emit_ready)
                    begin
                        cnt_next   = '0;
                        state_next = S_TAIL;
                    end
                end
            end
            S_FB_EMIT:
            begin
                emit_req.op   = OP_BYTE;
                emit_req.data = pick_byte(pattern, cnt_reg[2:0]);
                if (emit_ready)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == stop_reg)
                    begin
                        state_next = S_MATCH;
                    end
                end
            end
            S_REPL:
            begin
                if (cnt_reg >= r_eff)
                begin
                    cnt_next   = '0;
                    state_next = S_TAIL;
                end
                else
                begin
                    emit_req.op   = OP_BYTE;
                    emit_req.data = pick_byte(replace, cnt_reg[2:0]);
                    if (emit_ready)
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            S_TAIL:
            begin
                // end of string flushes the held prefix
                if (last_reg && cnt_reg < depth_reg)
                begin
                    emit_req.op   = OP_BYTE;
                    emit_req.data = pick_byte(pattern, cnt_reg[2:0]);
                    if (emit_ready)
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                emit_req.op = OP_CLOSE;
                if (emit_ready)
                begin
                    if (last_reg)
                    begin
                        depth_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pattern or length rewrite restarts the table build and drops held bytes
        if (build_start)
        begin
            state_next = S_BUILD;
            idx_next   = DEPTH_W'(1);
            k_next     = '0;
            depth_next = '0;
            fb_we      = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            k_reg     <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            stop_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            stop_reg  <= stop_next;
        end
    end

    // payload and table
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (fb_we)
        begin
            fb_reg[idx_reg[IDX_W-1:0]] <= fb_wdata;
        end
    end

endmodule

/* src/substring_replacer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// substring_replacer: streaming search and replace over a byte string
// Replaces each leftmost non-overlapping pattern hit and caps output length.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one source byte per
//   transfer, in_last set on the final byte of a string. Output channel
//   (out_valid/out_stall/out_data) returns zero or more result bytes per
//   input; run_last marks the last result of an input, string_end the last
//   of a string. A final input that yields no byte returns one bare marker.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   write it while no string is in flight.
// Sequencing:
//   An input that emits at most its own byte passes the idle, match, tail
//   and close states. Each byte replayed from the pattern or replacement
//   word (fallback, replacement, end-of-string flush) takes its own
//   sequencer step, and each fallback step and each replacement adds its
//   own step as well; the match sequencer and its single byte comparator
//   set this. Writing the search pattern or length rebuilds the fallback table, in_stall high.
//   A stalled result holds in the output register; the sequencer waits.
// Reset: registers return to defaults (limit 65535, empty search); no
//   clearing pass is needed.
// ---------------------------------------------------------------------------
module substring_replacer
    import ssr_pkg::*;
#(
    parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0]  pattern_reg;
    logic [DEPTH_W-1:0] slen_reg;
    logic [WORD_W-1:0]  replace_reg;
    logic [DEPTH_W-1:0] rlen_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_write;
    logic               build_start;
    emit_req_t          emit_req;
    logic               emit_ready;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign build_start = cfg_write && (cfg_index == REG_PATTERN || cfg_index == REG_SLEN);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            slen_reg    <= '0;
            replace_reg <= '0;
            rlen_reg    <= '0;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN: pattern_reg <= cfg_data;
                REG_SLEN:    slen_reg    <= cfg_data[DEPTH_W-1:0];
                REG_REPLACE: replace_reg <= cfg_data;
                REG_RLEN:    rlen_reg    <= cfg_data[DEPTH_W-1:0];
                REG_LIMIT:   limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ssr_scan #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .build_start (build_start),
        .pattern     (pattern_reg),
        .search_len  (slen_reg),
        .replace     (replace_reg),
        .replace_len (rlen_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .emit_req    (emit_req),
        .emit_ready  (emit_ready)
    );

    ssr_emit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (emit_req),
        .ready     (emit_ready),
        .limit     (limit_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // closing a string always produces a string_end transfer next cycle
    a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_req.op == OP_CLOSE && emit_req.last && emit_ready)
            |=> (out_valid && out_data.string_end))
        else $error("string close did not produce string_end");

    // a bare marker only ever ends a string
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.has_byte)
            |-> (out_data.run_last && out_data.string_end && out_data.out_byte == '0))
        else $error("bare marker without end flags");

    // end of string is always the last result of its input
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.string_end) |-> out_data.run_last)
        else $error("string_end without run_last");

    // search rewrite blocks input while the table rebuilds
    a_build_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        build_start |=> in_stall)
        else $error("input accepted during table build");

endmodule
